### design/pk3dd_pkg.sv
// shared types and constants for the packed 3-bit dictionary decoder
// no dependencies; imported by every module of the block
package pk3dd_pkg;

  localparam int CODE_W = 3;
  localparam int CHAR_W = 8;
  localparam int NUM_DICT = 7;
  localparam int CODES_PER_BYTE = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CHAR_W-1:0] char_t;

  localparam code_t END_CODE = 3'd7;

  // configuration register indexes: dictionary characters sit at 0 .. 6
  localparam logic [CFG_IDX_W-1:0] CFG_DICT_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DICT_LAST = 3'd6;

  typedef enum logic [1:0] {
    PHASE_0,
    PHASE_1,
    PHASE_2
  } phase_t;

  // one accepted byte as seen by the back end: its codes and how many results they give
  typedef struct packed {
    code_t [CODES_PER_BYTE-1:0] codes;
    logic [1:0] num;
  } entry_t;

endpackage

### design/pk3dd_front.sv
// front end: accepts bytes, splits them into 3-bit codes and finds the terminator
// depends on pk3dd_pkg; feeds pk3dd_queue
module pk3dd_front import pk3dd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic [7:0] in_byte,
  input  logic   restart,
  input  logic   q_full,
  output logic   push,
  output entry_t entry
);

  phase_t phase, phase_next;
  code_t  carry, carry_next;
  logic   stopped, stopped_next;

  phase_t eff_phase;
  code_t  eff_carry;
  logic   eff_stopped;
  phase_t adv_phase;
  code_t  adv_carry;
  code_t  c0, c1, c2;
  logic [1:0] ncodes;
  logic   hit;
  logic   accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // restart clears the stream state before this byte is decoded
  assign eff_phase = restart ? PHASE_0 : phase;
  assign eff_carry = restart ? '0 : carry;
  assign eff_stopped = restart ? 1'b0 : stopped;

  always_comb begin
    unique case (eff_phase)
      PHASE_1: begin
        c0 = eff_carry | {2'b00, in_byte[7]};
        c1 = in_byte[6:4];
        c2 = in_byte[3:1];
        ncodes = 2'd3;
        adv_carry = {in_byte[0], 2'b00};
        adv_phase = PHASE_2;
      end
      PHASE_2: begin
        c0 = eff_carry | {1'b0, in_byte[7:6]};
        c1 = in_byte[5:3];
        c2 = in_byte[2:0];
        ncodes = 2'd3;
        adv_carry = '0;
        adv_phase = PHASE_0;
      end
      default: begin
        c0 = in_byte[7:5];
        c1 = in_byte[4:2];
        c2 = END_CODE;
        ncodes = 2'd2;
        adv_carry = {in_byte[1:0], 1'b0};
        adv_phase = PHASE_1;
      end
    endcase
  end

  // terminator search: codes before it still count, the rest of the byte is dropped
  always_comb begin
    entry.codes = {c2, c1, c0};
    priority if (c0 == END_CODE) begin
      entry.num = 2'd1;
      hit = 1'b1;
    end else if (c1 == END_CODE) begin
      entry.num = 2'd2;
      hit = 1'b1;
    end else if (ncodes == 2'd3 && c2 == END_CODE) begin
      entry.num = 2'd3;
      hit = 1'b1;
    end else begin
      entry.num = ncodes;
      hit = 1'b0;
    end
  end

  assign push = accept && !eff_stopped;

  always_comb begin
    phase_next = phase;
    carry_next = carry;
    stopped_next = stopped;
    if (accept) begin
      phase_next = eff_phase;
      carry_next = eff_carry;
      stopped_next = eff_stopped;
      if (!eff_stopped) begin
        if (hit) begin
          stopped_next = 1'b1;
        end else begin
          phase_next = adv_phase;
          carry_next = adv_carry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_0;
      carry <= '0;
      stopped <= 1'b0;
    end else begin
      phase <= phase_next;
      carry <= carry_next;
      stopped <= stopped_next;
    end
  end

endmodule

### design/pk3dd_queue.sv
// short fifo of decoded byte entries between front and back end
// depends on pk3dd_pkg
module pk3dd_queue import pk3dd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   full,
  output logic   empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/pk3dd_back.sv
// back end: holds the dictionary and emits one result per cycle from the queue head
// while out_ready is high; depends on pk3dd_pkg; reads pk3dd_queue
module pk3dd_back import pk3dd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAR_W-1:0] cfg_data,
  input  logic   q_empty,
  input  entry_t head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic   char_valid,
  output logic   end_seen,
  output logic   last
);

  char_t dict [NUM_DICT];
  logic [1:0] idx, idx_next;
  code_t code;
  logic  load;
  logic  is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DICT; i++) begin
        dict[i] <= '0;
      end
    end else if (cfg_write && cfg_index >= CFG_DICT_FIRST && cfg_index <= CFG_DICT_LAST) begin
      dict[cfg_index] <= cfg_data;
    end
  end

  // output register refills whenever the queue has an entry and the register is empty or being taken
  assign load = !q_empty && (!out_valid || out_ready);
  assign code = head.codes[idx];
  assign is_last = (idx == head.num - 2'd1);
  assign pop = load && is_last;

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = is_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= is_last;
      if (code == END_CODE) begin
        out_char <= '0;
        char_valid <= 1'b0;
        end_seen <= 1'b1;
      end else begin
        out_char <= dict[code];
        char_valid <= 1'b1;
        end_seen <= 1'b0;
      end
    end
  end

endmodule

### design/packed_3bit_dictionary_decoder_top.sv
// Packed 3-bit code decoder. Each byte accepted on the input channel is split at once
// into its two or three 3-bit codes (eight codes per three bytes, MSB first) and placed
// in a small queue; the output side emits one result per cycle while the queue holds
// entries and out_ready is high, a dictionary character for codes 0 to 6 or an end
// marker for code 7, with last set on the final result of each byte. A byte is accepted
// while the queue has room and gives one to three results on the output, so the
// sustained rate is set by the single result port. After a terminator, bytes are
// accepted and dropped until restart is set.
// Dictionary registers 0 to 6 are written through cfg_write/cfg_index/cfg_data.
module packed_3bit_dictionary_decoder_top import pk3dd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       end_seen,
  output logic       last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic   push, pop, q_full, q_empty;
  entry_t wr_entry, head;
  logic [CNT_W-1:0] q_count;

  pk3dd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .restart  (restart),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  pk3dd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  pk3dd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .char_valid (char_valid),
    .end_seen   (end_seen),
    .last       (last)
  );

  // an end result carries no character and closes its byte
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_seen |-> !char_valid && out_char == '0 && last)
    else $error("end result with character or without last");

  // a restart byte always reaches the queue
  a_restart_push: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && restart |-> push)
    else $error("restart transaction dropped");

  // occupancy tracks pushes and pops
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> q_count == $past(q_count) + 1'b1)
    else $error("queue count did not advance on push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

### tb/tb.sv
// self-checking testbench for packed_3bit_dictionary_decoder_top: directed and random byte streams
// a scoreboard class predicts every decoded character and end marker and checks each transaction
// depends on pk3dd_pkg and the decoder top level in design/
module tb import pk3dd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 96;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_DICT_LAST + 3'd1;

  typedef enum {DICT_ZERO, DICT_ONES, DICT_RAND} dict_fill_t;

  typedef struct packed {
    char_t ch;
    logic  cv;
    logic  es;
    logic  lst;
  } dec_result_t;

  class dict_decode_board;
    char_t dict [NUM_DICT];
    phase_t phase;
    code_t carry;
    bit stopped;
    dec_result_t expected_q[$];
    int fails;
    int decoded;

    function new();
      foreach (dict[i]) dict[i] = '0;
      phase = PHASE_0;
      carry = '0;
      stopped = 1'b0;
      fails = 0;
      decoded = 0;
    endfunction

    function void set_char(logic [CFG_IDX_W-1:0] idx, char_t v);
      if (idx <= CFG_DICT_LAST) dict[idx] = v;
    endfunction

    function void push_result(char_t ch, logic cv, logic es);
      dec_result_t r;
      r.ch = ch;
      r.cv = cv;
      r.es = es;
      r.lst = 1'b0;
      expected_q.push_back(r);
    endfunction

    // predicts the results of one accepted byte
    function void note_byte(logic [7:0] b, logic rs);
      code_t codes [CODES_PER_BYTE];
      int n;
      code_t next_carry;
      phase_t next_phase;
      bit hit_end;
      int k;
      if (rs) begin
        phase = PHASE_0;
        carry = '0;
        stopped = 1'b0;
      end
      if (stopped) return;
      decoded++;
      case (phase)
        PHASE_1: begin
          codes[0] = {carry[2:1], b[7]};
          codes[1] = b[6:4];
          codes[2] = b[3:1];
          n = 3;
          next_carry = {b[0], 2'b00};
          next_phase = PHASE_2;
        end
        PHASE_2: begin
          codes[0] = {carry[2], b[7:6]};
          codes[1] = b[5:3];
          codes[2] = b[2:0];
          n = 3;
          next_carry = '0;
          next_phase = PHASE_0;
        end
        default: begin
          codes[0] = b[7:5];
          codes[1] = b[4:2];
          codes[2] = '0;
          n = 2;
          next_carry = {b[1:0], 1'b0};
          next_phase = PHASE_1;
        end
      endcase
      hit_end = 1'b0;
      for (k = 0; k < n && !hit_end; k++) begin
        if (codes[k] == END_CODE) begin
          push_result('0, 1'b0, 1'b1);
          stopped = 1'b1;
          hit_end = 1'b1;
        end else begin
          push_result(dict[codes[k]], 1'b1, 1'b0);
        end
      end
      // phase and carry stay put when the terminator cuts the byte short
      if (!hit_end) begin
        carry = next_carry;
        phase = next_phase;
      end
      expected_q[$].lst = 1'b1;
    endfunction

    function void check_result(char_t ch, logic cv, logic es, logic lst);
      dec_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: out_char %h char_valid %b end_seen %b last %b",
               ch, cv, es, lst);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (ch !== e.ch) begin
        $error("out_char mismatch: expected %h, got %h", e.ch, ch);
        fails++;
      end
      if (cv !== e.cv) begin
        $error("char_valid mismatch: expected %b, got %b", e.cv, cv);
        fails++;
      end
      if (es !== e.es) begin
        $error("end_seen mismatch: expected %b, got %b", e.es, es);
        fails++;
      end
      if (lst !== e.lst) begin
        $error("last mismatch: expected %b, got %b", e.lst, lst);
        fails++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_byte;
  logic restart;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_char;
  logic char_valid;
  logic end_seen;
  logic last;

  dict_decode_board sb;
  bit no_idle;
  int quiet_cycles;

  packed_3bit_dictionary_decoder_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .char_valid(char_valid),
    .end_seen(end_seen),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // transaction monitor: inputs are noted before results are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_byte, restart);
      if (out_valid && out_ready) sb.check_result(out_char, char_valid, end_seen, last);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_byte = b;
    restart = rs;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    // dropped bytes never reach the queue, so this wait only adds idle margin
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_char(idx, v);
  endtask

  task automatic load_dict(input dict_fill_t fill);
    logic [7:0] v;
    for (int i = CFG_DICT_FIRST; i <= CFG_DICT_LAST; i++) begin
      case (fill)
        DICT_ZERO: v = 8'h00;
        DICT_ONES: v = 8'hff;
        default:   v = 8'($urandom_range(0, 255));
      endcase
      write_reg(i[CFG_IDX_W-1:0], v);
    end
    // out-of-range index must not disturb the dictionary
    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
  endtask

  // one well-formed stream: random codes, usually a terminator, random fill bits
  task automatic send_stream();
    logic bits[$];
    logic [7:0] b;
    code_t c;
    int ncodes;
    bit term;
    ncodes = $urandom_range(1, 24);
    term = ($urandom_range(0, 9) != 0);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < ncodes; i++) begin
      c = 3'($urandom_range(0, 6));
      bits.push_back(c[2]);
      bits.push_back(c[1]);
      bits.push_back(c[0]);
    end
    if (term) begin
      repeat (CODE_W) bits.push_back(1'b1);
      if ($urandom_range(0, 2) == 0) repeat (8) bits.push_back(1'($urandom_range(0, 1)));
    end
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(0, 1)));
    for (int k = 0; k < bits.size() / 8; k++) begin
      for (int j = 0; j < 8; j++) b[7-j] = bits[8*k+j];
      send_byte(b, k == 0);
    end
  endtask

  task automatic random_phase(input dict_fill_t fill, input int count);
    int goal;
    wait_drained();
    load_dict(fill);
    goal = sb.decoded + count;
    while (sb.decoded < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        no_idle = 1'b0;
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        send_stream();
      end
    end
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!no_idle) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    restart = 1'b0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_dict(DICT_RAND);
    // codes 0 through 7 packed into one three-byte group
    send_byte(8'h05, 1'b1);
    send_byte(8'h39, 1'b0);
    send_byte(8'h77, 1'b0);
    // terminator as first code of a phase-0 byte, then bytes while stopped
    send_byte(8'he0, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    // terminator in the code straddling into a phase-1 byte
    send_byte(8'h03, 1'b1);
    send_byte(8'h80, 1'b0);
    // terminator in the code straddling into a phase-2 byte
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hc0, 1'b0);
    // terminator mid-byte and as the last code of a group
    send_byte(8'h1c, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h07, 1'b0);
    // restart in the middle of a live stream, extremes of the byte
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h24, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hb6, 1'b0);
    send_byte(8'hdb, 1'b0);

    random_phase(DICT_ONES, RANDOM_BYTES / 4);
    random_phase(DICT_RAND, RANDOM_BYTES / 4);
    random_phase(DICT_ZERO, RANDOM_BYTES / 4);
    random_phase(DICT_RAND, RANDOM_BYTES / 4);

    no_idle = 1'b0;
    wait_drained();
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
